### rtl/uctw_pkg.sv
// Shared types, constants and the display-width table of the UTF-8 cell-width truncator.
`default_nettype none

package uctw_pkg;

  localparam int UCTW_OUT_DEPTH = 4;

  localparam logic [15:0] CFG_RESET = 16'hFFFF;

  localparam logic REG_CELL_LIMIT   = 1'b0;
  localparam logic REG_OUT_CAPACITY = 1'b1;

  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;
  localparam logic [20:0] REPL_CP = 21'h00FFFD;

  localparam logic [7:0] LEAD2_LO   = 8'hC2;
  localparam logic [7:0] LEAD2_HI   = 8'hDF;
  localparam logic [7:0] LEAD3_LO   = 8'hE0;
  localparam logic [7:0] LEAD3_HI   = 8'hEF;
  localparam logic [7:0] LEAD4_LO   = 8'hF0;
  localparam logic [7:0] LEAD4_HI   = 8'hF4;
  localparam logic [7:0] LEAD_SURR  = 8'hED;
  localparam logic [7:0] CONT_LO    = 8'h80;
  localparam logic [7:0] CONT_HI    = 8'hBF;
  localparam logic [7:0] E0_CONT_LO = 8'hA0;
  localparam logic [7:0] ED_CONT_HI = 8'h9F;
  localparam logic [7:0] F0_CONT_LO = 8'h90;
  localparam logic [7:0] F4_CONT_HI = 8'h8F;

  localparam int WIDE_N = 15;
  localparam logic [20:0] WIDE_LO [WIDE_N] = '{
    21'h003000, 21'h003040, 21'h001100, 21'h003130, 21'h0031F0,
    21'h003400, 21'h004E00, 21'h00A960, 21'h00AC00, 21'h00D7B0,
    21'h00F900, 21'h00FF01, 21'h00FFE0, 21'h020000, 21'h030000
  };
  localparam logic [20:0] WIDE_HI [WIDE_N] = '{
    21'h00303F, 21'h0030FF, 21'h0011FF, 21'h00318F, 21'h0031FF,
    21'h004DBF, 21'h009FFF, 21'h00A97F, 21'h00D7A3, 21'h00D7FF,
    21'h00FAFF, 21'h00FF60, 21'h00FFE6, 21'h02FFFF, 21'h0323AF
  };

  function automatic logic [1:0] cell_width(input logic [20:0] cp);
    logic wide;
    wide = 1'b0;
    for (int i = 0; i < WIDE_N; i++) begin
      if (cp >= WIDE_LO[i] && cp <= WIDE_HI[i]) begin
        wide = 1'b1;
      end
    end
    return wide ? 2'd2 : 2'd1;
  endfunction

  typedef struct packed {
    logic        has_byte;
    logic [7:0]  out_byte;
    logic        string_done;
    logic [15:0] cell_total;
  } res_t;

  typedef struct packed {
    logic valid;
    logic res;
    logic item_end;
    res_t payload;
  } ev_t;

endpackage

`default_nettype wire

### rtl/uctw_engine.sv
// Decoder engine: holds the open sequence, resolves characters in turn, emits their bytes.
`default_nettype none

module uctw_engine
  import uctw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic        in_kind,
  input  wire logic [7:0]  in_byte,
  input  wire logic [15:0] cell_limit,
  input  wire logic [15:0] out_capacity,
  output ev_t              ev,
  input  wire logic        ev_ready
);

  typedef enum logic [1:0] {CLS_DONE, CLS_PREFIX, CLS_BAD} cls_t;

  localparam logic [2:0] LIMIT_DATA  = 3'd3;
  localparam logic [2:0] LIMIT_FINAL = 3'd4;

  logic [7:0]  pend_r [4];
  logic [7:0]  pend_nxt [4];
  logic [2:0]  pend_n_r, pend_n_nxt;
  logic [15:0] cells_r, cells_nxt;
  logic [15:0] bytes_r, bytes_nxt;
  logic        halted_r, halted_nxt;
  logic        act_r, act_nxt;
  logic        final_r, final_nxt;
  logic [2:0]  chars_r, chars_nxt;
  logic [7:0]  emit_b_r [3];
  logic [7:0]  emit_b_nxt [3];
  logic [1:0]  emit_cnt_r, emit_cnt_nxt;
  logic        end_after_r, end_after_nxt;

  logic [7:0]  lead;
  logic [2:0]  need;
  logic [7:0]  lo2, hi2;
  logic        lead_bad, bad1, bad2, bad3;
  cls_t        cls;
  logic [2:0]  len;
  logic [20:0] cp;

  logic [2:0]  limit;
  logic        cont, resolve, is_bad, fits, emit_now, simple_end, fire;
  logic [2:0]  nb, shift, pend_n_s, chars_s;
  logic [1:0]  cw;
  logic [7:0]  pend_sh [4];

  function automatic logic is_cont(input logic [7:0] b);
    return b >= CONT_LO && b <= CONT_HI;
  endfunction

  always_comb begin
    lead = pend_r[0];
    lo2  = CONT_LO;
    hi2  = CONT_HI;
    need = 3'd1;
    lead_bad = 1'b0;
    if (!lead[7]) begin
      need = 3'd1;
    end else if (lead >= LEAD2_LO && lead <= LEAD2_HI) begin
      need = 3'd2;
    end else if (lead >= LEAD3_LO && lead <= LEAD3_HI) begin
      need = 3'd3;
    end else if (lead >= LEAD4_LO && lead <= LEAD4_HI) begin
      need = 3'd4;
    end else begin
      lead_bad = 1'b1;
    end
    if (lead == LEAD3_LO)  lo2 = E0_CONT_LO;
    if (lead == LEAD_SURR) hi2 = ED_CONT_HI;
    if (lead == LEAD4_LO)  lo2 = F0_CONT_LO;
    if (lead == LEAD4_HI)  hi2 = F4_CONT_HI;
    bad1 = (pend_n_r > 3'd1) && (need > 3'd1) &&
           (!is_cont(pend_r[1]) || pend_r[1] < lo2 || pend_r[1] > hi2);
    bad2 = (pend_n_r > 3'd2) && (need > 3'd2) && !is_cont(pend_r[2]);
    bad3 = (pend_n_r > 3'd3) && (need > 3'd3) && !is_cont(pend_r[3]);

    len = need;
    if (lead_bad || bad1 || bad2 || bad3) begin
      cls = CLS_BAD;
    end else if (pend_n_r < need) begin
      cls = CLS_PREFIX;
    end else begin
      cls = CLS_DONE;
    end

    case (need)
      3'd2:    cp = {10'b0, lead[4:0], pend_r[1][5:0]};
      3'd3:    cp = {5'b0, lead[3:0], pend_r[1][5:0], pend_r[2][5:0]};
      3'd4:    cp = {lead[2:0], pend_r[1][5:0], pend_r[2][5:0], pend_r[3][5:0]};
      default: cp = {13'b0, lead};
    endcase
  end

  always_comb begin
    limit      = final_r ? LIMIT_FINAL : LIMIT_DATA;
    cont       = (pend_n_r != 3'd0) && (chars_r < limit) && !halted_r;
    resolve    = cont && !(cls == CLS_PREFIX && !final_r);
    is_bad     = (cls != CLS_DONE);
    nb         = is_bad ? 3'd3 : len;
    shift      = is_bad ? 3'd1 : len;
    cw         = is_bad ? cell_width(REPL_CP) : cell_width(cp);
    fits       = (({1'b0, cells_r} + {15'b0, cw}) <= {1'b0, cell_limit}) &&
                 (({1'b0, bytes_r} + {14'b0, nb}) < {1'b0, out_capacity});
    emit_now   = resolve && fits;
    pend_n_s   = pend_n_r - shift;
    chars_s    = chars_r + 3'd1;
    simple_end = (pend_n_s == 3'd0) || (chars_s == limit);

    pend_sh = pend_r;
    case (shift)
      3'd1: begin
        pend_sh[0] = pend_r[1];
        pend_sh[1] = pend_r[2];
        pend_sh[2] = pend_r[3];
      end
      3'd2: begin
        pend_sh[0] = pend_r[2];
        pend_sh[1] = pend_r[3];
      end
      3'd3: begin
        pend_sh[0] = pend_r[3];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ev = '0;
    if (act_r) begin
      ev.valid = 1'b1;
      if (emit_cnt_r != 2'd0) begin
        ev.res              = 1'b1;
        ev.payload.has_byte = 1'b1;
        ev.payload.out_byte = emit_b_r[0];
        ev.item_end         = (emit_cnt_r == 2'd1) && end_after_r;
      end else if (emit_now) begin
        ev.res              = 1'b1;
        ev.payload.has_byte = 1'b1;
        ev.payload.out_byte = is_bad ? REPL_B0 : pend_r[0];
        ev.item_end         = (nb == 3'd1) && simple_end && !final_r;
      end else if (final_r) begin
        ev.res                 = 1'b1;
        ev.payload.string_done = 1'b1;
        ev.payload.cell_total  = cells_r;
        ev.item_end            = 1'b1;
      end else begin
        ev.item_end = 1'b1;
      end
    end
  end

  assign fire      = ev.valid && ev_ready;
  assign in_tready = !act_r || (fire && ev.item_end);

  always_comb begin
    pend_nxt      = pend_r;
    pend_n_nxt    = pend_n_r;
    cells_nxt     = cells_r;
    bytes_nxt     = bytes_r;
    halted_nxt    = halted_r;
    act_nxt       = act_r;
    final_nxt     = final_r;
    chars_nxt     = chars_r;
    emit_b_nxt    = emit_b_r;
    emit_cnt_nxt  = emit_cnt_r;
    end_after_nxt = end_after_r;

    if (fire) begin
      if (emit_cnt_r != 2'd0) begin
        emit_b_nxt[0] = emit_b_r[1];
        emit_b_nxt[1] = emit_b_r[2];
        emit_cnt_nxt  = emit_cnt_r - 2'd1;
      end else if (emit_now) begin
        cells_nxt     = cells_r + {14'b0, cw};
        bytes_nxt     = bytes_r + {13'b0, nb};
        pend_nxt      = pend_sh;
        pend_n_nxt    = pend_n_s;
        chars_nxt     = chars_s;
        emit_cnt_nxt  = 2'(nb - 3'd1);
        end_after_nxt = simple_end && !final_r;
        if (is_bad) begin
          emit_b_nxt[0] = REPL_B1;
          emit_b_nxt[1] = REPL_B2;
        end else begin
          emit_b_nxt[0] = pend_r[1];
          emit_b_nxt[1] = pend_r[2];
          emit_b_nxt[2] = pend_r[3];
        end
      end else if (final_r) begin
        pend_n_nxt = 3'd0;
        cells_nxt  = 16'd0;
        bytes_nxt  = 16'd0;
        halted_nxt = 1'b0;
      end else begin
        if (resolve) begin
          halted_nxt = 1'b1;
        end
        if (pend_n_r == 3'd4) begin
          pend_n_nxt = 3'd3;
        end
      end
      if (ev.item_end) begin
        act_nxt = 1'b0;
      end
    end

    if (in_tvalid && in_tready) begin
      act_nxt   = 1'b1;
      final_nxt = in_kind;
      chars_nxt = 3'd0;
      if (!in_kind && !halted_nxt) begin
        pend_nxt[pend_n_nxt[1:0]] = in_byte;
        pend_n_nxt = pend_n_nxt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_n_r    <= 3'd0;
      cells_r     <= 16'd0;
      bytes_r     <= 16'd0;
      halted_r    <= 1'b0;
      act_r       <= 1'b0;
      final_r     <= 1'b0;
      chars_r     <= 3'd0;
      emit_cnt_r  <= 2'd0;
      end_after_r <= 1'b0;
    end else begin
      pend_n_r    <= pend_n_nxt;
      cells_r     <= cells_nxt;
      bytes_r     <= bytes_nxt;
      halted_r    <= halted_nxt;
      act_r       <= act_nxt;
      final_r     <= final_nxt;
      chars_r     <= chars_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      end_after_r <= end_after_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r   <= pend_nxt;
    emit_b_r <= emit_b_nxt;
  end

endmodule

`default_nettype wire

### rtl/uctw_outq.sv
// Result stage: holds the newest result until its last-of-item flag is known, then queues it.
`default_nettype none

module uctw_outq
  import uctw_pkg::*;
#(
  parameter int OUT_DEPTH = UCTW_OUT_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire ev_t  ev,
  output logic      ev_ready,
  output logic      out_tvalid,
  input  wire logic out_tready,
  output res_t      out_res,
  output logic      out_last
);

  localparam int PW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int CW = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    res_t res;
    logic last;
  } ent_t;

  ent_t          mem_r [OUT_DEPTH];
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] wr_ptr_p1;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] free;
  res_t          hold_r, hold_nxt;
  logic          hold_v_r, hold_v_nxt;

  ent_t          e0, e1;
  logic [1:0]    npush;
  logic          fire, pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(OUT_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    e0         = '0;
    e1         = '0;
    npush      = 2'd0;
    hold_nxt   = hold_r;
    hold_v_nxt = hold_v_r;
    if (hold_v_r) begin
      if (ev.res && ev.item_end) begin
        e0         = '{res: hold_r, last: 1'b0};
        e1         = '{res: ev.payload, last: 1'b1};
        npush      = 2'd2;
        hold_v_nxt = 1'b0;
      end else if (ev.res) begin
        e0       = '{res: hold_r, last: 1'b0};
        npush    = 2'd1;
        hold_nxt = ev.payload;
      end else begin
        e0         = '{res: hold_r, last: 1'b1};
        npush      = ev.item_end ? 2'd1 : 2'd0;
        hold_v_nxt = !ev.item_end;
      end
    end else if (ev.res && ev.item_end) begin
      e0    = '{res: ev.payload, last: 1'b1};
      npush = 2'd1;
    end else if (ev.res) begin
      hold_nxt   = ev.payload;
      hold_v_nxt = 1'b1;
    end
  end

  assign free       = CW'(OUT_DEPTH) - cnt_r;
  assign ev_ready   = ({{(CW-2){1'b0}}, npush} <= free);
  assign fire       = ev.valid && ev_ready;
  assign out_tvalid = (cnt_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign out_res    = mem_r[rd_ptr_r].res;
  assign out_last   = mem_r[rd_ptr_r].last;
  assign wr_ptr_p1  = ptr_inc(wr_ptr_r);

  always_comb begin
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    cnt_nxt    = cnt_r - {{(CW-1){1'b0}}, pop};
    if (fire) begin
      case (npush)
        2'd1:    wr_ptr_nxt = wr_ptr_p1;
        2'd2:    wr_ptr_nxt = ptr_inc(wr_ptr_p1);
        default: wr_ptr_nxt = wr_ptr_r;
      endcase
      cnt_nxt = cnt_nxt + {{(CW-2){1'b0}}, npush};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
      hold_v_r <= 1'b0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
      if (fire) begin
        hold_v_r <= hold_v_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      hold_r <= hold_nxt;
      if (npush != 2'd0) begin
        mem_r[wr_ptr_r] <= e0;
      end
      if (npush == 2'd2) begin
        mem_r[wr_ptr_p1] <= e1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/utf8_cell_width_truncator_top.sv
// Top level of the UTF-8 cell-width truncator: register port, engine and result queue.
`default_nettype none

// Copies a UTF-8 string, one byte per input transfer, truncated to a display-cell budget
// and a byte capacity that keeps room for a terminator. Malformed input becomes U+FFFD
// (EF BF BD). The bytes of each character leave one per cycle, while the result queue has
// room, through a single result path, so an input transfer holds input until its last
// byte has left, and longer when, after emitting bytes, it ends on an open sequence or on
// the budget stop. Plain ASCII text streams at one byte per cycle while the queue has
// room; a byte that completes an n-byte character holds input while its n bytes leave,
// and a byte that breaks a held sequence can give up to three replacements. An end
// marker turns each held byte into a replacement while it fits, then gives the result
// that carries the cell total. The newest result of an input item is held back so that
// tlast can mark the last result of that item; a small result queue (OUT_DEPTH entries)
// keeps input moving while the output side stalls. No clearing pass after reset.
module utf8_cell_width_truncator_top
  import uctw_pkg::*;
#(
  parameter int OUT_DEPTH = UCTW_OUT_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,     // [7:0] in_byte
  input  wire logic        in_tuser,     // [0] kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,    // [7:0] out_byte, [23:8] cell_total
  output logic [1:0]       out_tuser,    // [0] has_byte, [1] string_done
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [15:0] cell_limit_r, cell_limit_nxt;
  logic [15:0] out_capacity_r, out_capacity_nxt;
  logic        cfg_wr;
  ev_t         ev;
  logic        ev_ready;
  res_t        out_res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cell_limit_nxt   = cell_limit_r;
    out_capacity_nxt = out_capacity_r;
    if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_CELL_LIMIT:   cell_limit_nxt   = cfg_pwdata[15:0];
        REG_OUT_CAPACITY: out_capacity_nxt = cfg_pwdata[15:0];
        default:          cell_limit_nxt   = cell_limit_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_CELL_LIMIT:   cfg_prdata = {16'b0, cell_limit_r};
      REG_OUT_CAPACITY: cfg_prdata = {16'b0, out_capacity_r};
      default:          cfg_prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_limit_r   <= CFG_RESET;
      out_capacity_r <= CFG_RESET;
    end else begin
      cell_limit_r   <= cell_limit_nxt;
      out_capacity_r <= out_capacity_nxt;
    end
  end

  uctw_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_kind      (in_tuser),
    .in_byte      (in_tdata),
    .cell_limit   (cell_limit_r),
    .out_capacity (out_capacity_r),
    .ev           (ev),
    .ev_ready     (ev_ready)
  );

  uctw_outq #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .ev         (ev),
    .ev_ready   (ev_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res),
    .out_last   (out_tlast)
  );

  assign out_tdata = {out_res.cell_total, out_res.out_byte};
  assign out_tuser = {out_res.string_done, out_res.has_byte};

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast && !out_tuser[0])
    else $error("string_done transfer must be last and carry no byte");

  a_total_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tdata[23:8] == 16'd0)
    else $error("cell_total nonzero on a byte transfer");

  a_no_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'b00)
    else $error("result carries neither byte nor total");

  a_engine_event: assert property (@(posedge clk) disable iff (!rst_n)
    ev.valid && !ev.res |-> ev.item_end)
    else $error("engine event carries neither result nor item end");

endmodule

`default_nettype wire
